FILE: src/nirw_pkg.sv
// ----------------------------------------------------------------------------
// nirw_pkg: shared types and constants
// Item formats, status codes and window sizing for the nonce/replay block.
// ----------------------------------------------------------------------------
`default_nettype none

package nirw_pkg;

    localparam int WINDOW_BITS = 64;
    localparam int IDX_W       = $clog2(WINDOW_BITS);
    localparam int SEQ_W       = 63;
    localparam int NONCE_W     = 64;
    localparam int NONCE_BYTES = 8;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    localparam logic [1:0] REG_IS_SERVER    = 2'd0;
    localparam logic [1:0] REG_MTU_BYTES    = 2'd1;
    localparam logic [1:0] REG_CIPHER_ADDED = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_BAD_DIR   = 3'd3,
        ST_REPLAY    = 3'd4
    } t_status;

    typedef struct packed {
        logic                 opcode;
        logic [15:0]          byte_length;
        logic [NONCE_W-1:0]   received_nonce;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [NONCE_W-1:0]   issued_nonce;
        logic                 newest;
    } t_out_item;

    typedef struct packed {
        logic        is_server;
        logic [15:0] mtu_bytes;
        logic [7:0]  cipher_added_bytes;
    } t_cfg;

endpackage

`default_nettype wire

FILE: src/nirw_cfg.sv
// ----------------------------------------------------------------------------
// nirw_cfg: configuration registers
// APB-style register file for side, MTU and cipher overhead.
// ----------------------------------------------------------------------------
`default_nettype none

module nirw_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [nirw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [nirw_pkg::DATA_W-1:0] pwdata,
    output logic      [nirw_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output nirw_pkg::t_cfg                  o_cfg
);
    import nirw_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.is_server          <= 1'b0;
            r_cfg.mtu_bytes          <= 16'd1400;
            r_cfg.cipher_added_bytes <= 8'd16;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_IS_SERVER:    r_cfg.is_server          <= pwdata[0];
                REG_MTU_BYTES:    r_cfg.mtu_bytes          <= pwdata[15:0];
                REG_CIPHER_ADDED: r_cfg.cipher_added_bytes <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_IS_SERVER:    prdata = {31'd0, r_cfg.is_server};
            REG_MTU_BYTES:    prdata = {16'd0, r_cfg.mtu_bytes};
            REG_CIPHER_ADDED: prdata = {24'd0, r_cfg.cipher_added_bytes};
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/nirw_proc.sv
// ----------------------------------------------------------------------------
// nirw_proc: nonce issue and replay window core
// Holds the send counter and receive window; computes one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module nirw_proc (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire nirw_pkg::t_in_item i_item,
    input  wire nirw_pkg::t_cfg     i_cfg,
    output nirw_pkg::t_out_item     o_result
);
    import nirw_pkg::*;

    logic [NONCE_W-1:0]     r_counter;
    logic [NONCE_W-1:0]     n_counter;
    logic [SEQ_W-1:0]       r_high;
    logic [SEQ_W-1:0]       n_high;
    logic [WINDOW_BITS-1:0] r_bitmap;
    logic [WINDOW_BITS-1:0] n_bitmap;

    logic [16:0]            w_send_len;
    logic [SEQ_W-1:0]       w_seq;
    logic [SEQ_W-1:0]       w_adv;
    logic [SEQ_W-1:0]       w_dist;
    logic [IDX_W-1:0]       w_adv_idx;
    logic [IDX_W-1:0]       w_dist_idx;

    assign w_send_len = {1'b0, i_item.byte_length} + 17'(NONCE_BYTES)
                      + {9'd0, i_cfg.cipher_added_bytes};
    assign w_seq      = i_item.received_nonce[SEQ_W-1:0];
    assign w_adv      = w_seq - r_high;
    assign w_dist     = r_high - w_seq;
    assign w_adv_idx  = w_adv[IDX_W-1:0];
    assign w_dist_idx = w_dist[IDX_W-1:0];

    always_comb begin
        o_result  = '0;
        n_counter = r_counter;
        n_high    = r_high;
        n_bitmap  = r_bitmap;
        if (i_item.opcode == OP_SEND) begin
            if (w_send_len > {1'b0, i_cfg.mtu_bytes}) begin
                o_result.status = ST_TOO_LARGE;
            end else if (r_counter[NONCE_W-1]) begin
                o_result.status = ST_EXHAUSTED;
            end else begin
                o_result.issued_nonce = {i_cfg.is_server, r_counter[SEQ_W-1:0]};
                n_counter             = r_counter + 64'd1;
            end
        end else begin
            if (i_item.byte_length > i_cfg.mtu_bytes) begin
                o_result.status = ST_TOO_LARGE;
            end else if (i_item.received_nonce[NONCE_W-1] == i_cfg.is_server
                         || w_seq == '0) begin
                o_result.status = ST_BAD_DIR;
            end else if (w_seq > r_high) begin
                if (w_adv >= SEQ_W'(WINDOW_BITS)) begin
                    n_bitmap = '0;
                end else begin
                    n_bitmap = r_bitmap << w_adv_idx;
                end
                n_bitmap[0]     = 1'b1;
                n_high          = w_seq;
                o_result.newest = 1'b1;
            end else if (w_dist >= SEQ_W'(WINDOW_BITS) || r_bitmap[w_dist_idx]) begin
                o_result.status = ST_REPLAY;
            end else begin
                n_bitmap[w_dist_idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= 64'd1;
            r_high    <= '0;
            r_bitmap  <= '0;
        end else if (i_fire) begin
            r_counter <= n_counter;
            r_high    <= n_high;
            r_bitmap  <= n_bitmap;
        end
    end

endmodule

`default_nettype wire

FILE: src/nonce_issue_and_replay_window.sv
// ----------------------------------------------------------------------------
// nonce_issue_and_replay_window: per-hop nonce issue and anti-replay window
// Each item passes the input register, then the result register. Throughput: one item per
// cycle while the result side is not stalled, set by the single compare/subtract/shift pass
// between them. Synchronous reset clears valid flags and window, sets the send counter to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module nonce_issue_and_replay_window (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire nirw_pkg::t_in_item          i_in_item,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output nirw_pkg::t_out_item              o_out_item,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [nirw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [nirw_pkg::DATA_W-1:0] pwdata,
    output logic      [nirw_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import nirw_pkg::*;

    t_cfg      w_cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item w_result;
    t_out_item r_out;
    logic      r_out_valid;
    logic      w_fire;

    assign w_fire      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_fire;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    nirw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    nirw_proc u_proc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

`ifndef SYNTHESIS
    a_issue_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.issued_nonce == '0)
        else $error("nonce issued on a rejected item");

    a_newest_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.newest |-> o_out_item.status == ST_OK)
        else $error("newest flagged on a rejected item");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    a_fire_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("processed item did not reach the result register");
`endif

endmodule

`default_nettype wire

FILE: test/tb_nonce_issue_and_replay_window.sv
// ----------------------------------------------------------------------------
// tb_nonce_issue_and_replay_window: self-checking bench for the nonce block
// A fixed table of sends and receives runs first. Random traffic follows under
// several register settings, with bursts of idle and stall on both sides. Every
// result is checked against its fixed table answer or an in-bench model of the counter and replay window.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_nonce_issue_and_replay_window;
    import nirw_pkg::*;

    localparam int          HOLD_CYCLES = 60;
    localparam int          PHASE_ITEMS = 306;
    localparam int          NUM_PHASES  = 5;
    localparam logic [63:0] DIR_MASK    = 64'h8000_0000_0000_0000;
    localparam logic [62:0] SEQ_MAX     = '1;

    typedef struct {
        t_in_item  item;
        bit        fixed;
        t_out_item answer;
    } t_plan_row;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    t_in_item          in_item;
    logic              out_valid;
    logic              out_stall;
    t_out_item         out_item;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    t_cfg                   cfg;
    logic [63:0]            send_ctr;
    logic [SEQ_W-1:0]       hi_seq;
    logic [WINDOW_BITS-1:0] seen_map;

    t_plan_row plan[$];
    t_plan_row known_answers[$];
    t_out_item pending_results[$];
    t_cfg      phase_cfg[NUM_PHASES];
    int        err_count;
    int        n_items;
    int        n_newest;
    int        status_count[5];
    bit        quiet;
    bit        hold_req;

    nonce_issue_and_replay_window u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_out_item nonce_window_step(input t_in_item it);
        t_out_item        r;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] gap;
        r        = '0;
        r.status = ST_OK;
        seq      = it.received_nonce[SEQ_W-1:0];
        if (it.opcode == OP_SEND) begin
            if (int'(it.byte_length) + NONCE_BYTES + int'(cfg.cipher_added_bytes)
                    > int'(cfg.mtu_bytes)) begin
                r.status = ST_TOO_LARGE;
            end else if (send_ctr[63]) begin
                r.status = ST_EXHAUSTED;
            end else begin
                r.issued_nonce = {cfg.is_server, send_ctr[62:0]};
                send_ctr       = send_ctr + 64'd1;
            end
        end else if (it.byte_length > cfg.mtu_bytes) begin
            r.status = ST_TOO_LARGE;
        end else if (it.received_nonce[63] == cfg.is_server || seq == '0) begin
            r.status = ST_BAD_DIR;
        end else if (seq > hi_seq) begin
            gap = seq - hi_seq;
            if (gap >= WINDOW_BITS) begin
                seen_map = '0;
            end else begin
                seen_map = seen_map << gap;
            end
            seen_map[0] = 1'b1;
            hi_seq      = seq;
            r.newest    = 1'b1;
        end else begin
            gap = hi_seq - seq;
            if (gap >= WINDOW_BITS || seen_map[gap[IDX_W-1:0]]) begin
                r.status = ST_REPLAY;
            end else begin
                seen_map[gap[IDX_W-1:0]] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] pick_len(input bit is_send);
        int lim;
        int k;
        lim = int'(cfg.mtu_bytes);
        if (is_send) begin
            lim = lim - NONCE_BYTES - int'(cfg.cipher_added_bytes);
        end
        k = $urandom_range(0, 9);
        if (k == 0 || lim < 0) begin
            return 16'($urandom);
        end
        if (k == 1 && lim < 65535) begin
            return 16'(lim + 1);
        end
        if (k == 2) begin
            return 16'(lim);
        end
        return 16'($urandom_range(0, lim));
    endfunction

    function automatic t_in_item random_item();
        t_in_item         it;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] step;
        logic             dir;
        int               k;
        it.opcode         = ($urandom_range(0, 9) < 4) ? OP_SEND : OP_RECV;
        it.byte_length    = pick_len(it.opcode == OP_SEND);
        it.received_nonce = {$urandom, $urandom};
        if (it.opcode == OP_SEND) begin
            return it;
        end
        k    = $urandom_range(0, 99);
        dir  = ~cfg.is_server;
        step = ($urandom_range(0, 4) == 0) ? SEQ_W'($urandom_range(1, 1000))
                                           : SEQ_W'($urandom_range(1, 8));
        if (step > SEQ_MAX - hi_seq) begin
            step = SEQ_MAX - hi_seq;
        end
        seq = hi_seq + step;
        if (k >= 45 && k < 85) begin
            step = SEQ_W'($urandom_range(0, 70));
            seq  = (step > hi_seq) ? '0 : hi_seq - step;
        end else if (k >= 85 && k < 92) begin
            dir = cfg.is_server;
        end else if (k >= 92 && k < 96) begin
            seq = '0;
        end
        if (k < 96) begin
            it.received_nonce = {dir, seq};
        end
        return it;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_count < 40) begin
            $display("%0t: mismatch in %s: got %h, expected %h", $time, field, got, want);
        end
        err_count++;
    endtask

    task automatic add_row(input logic op, input logic [15:0] len, input logic [63:0] nonce,
                           input bit fixed, input t_status st, input logic [63:0] iss,
                           input logic nw);
        t_plan_row row;
        row.item.opcode         = op;
        row.item.byte_length    = len;
        row.item.received_nonce = nonce;
        row.fixed               = fixed;
        row.answer.status       = st;
        row.answer.issued_nonce = iss;
        row.answer.newest       = nw;
        plan = {plan, row};
    endtask

    task automatic build_plan();
        logic [63:0] walk[10] = '{64, 1, 2, 3, 63, 63, 300, 236, 237, 299};
        add_row(OP_SEND, 16'd0,     64'd0,        1, ST_OK,        64'd1, 1'b0);
        add_row(OP_SEND, 16'd1376,  '1,           1, ST_OK,        64'd2, 1'b0);
        add_row(OP_SEND, 16'd1377,  64'd0,        1, ST_TOO_LARGE, 64'd0, 1'b0);
        add_row(OP_SEND, 16'hFFFF,  '1,           1, ST_TOO_LARGE, 64'd0, 1'b0);
        add_row(OP_RECV, 16'd1401,  '1,           1, ST_TOO_LARGE, 64'd0, 1'b0);
        add_row(OP_RECV, 16'hFFFF,  64'd0,        1, ST_TOO_LARGE, 64'd0, 1'b0);
        add_row(OP_RECV, 16'd1400,  64'd5,        1, ST_BAD_DIR,   64'd0, 1'b0);
        add_row(OP_RECV, 16'd0,     DIR_MASK,     1, ST_BAD_DIR,   64'd0, 1'b0);
        add_row(OP_RECV, 16'd100,   DIR_MASK | 1, 1, ST_OK,        64'd0, 1'b1);
        add_row(OP_RECV, 16'd100,   DIR_MASK | 1, 1, ST_REPLAY,    64'd0, 1'b0);
        foreach (walk[i]) begin
            add_row(OP_RECV, 16'(i * 7), DIR_MASK | walk[i], 0, ST_OK, 64'd0, 1'b0);
        end
        add_row(OP_SEND, 16'd0,     64'd0,        1, ST_OK,        64'd3, 1'b0);
        add_row(OP_RECV, 16'd1401,  '1,           1, ST_TOO_LARGE, 64'd0, 1'b0);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_cfg(input t_cfg c);
        apb_write(REG_IS_SERVER,    DATA_W'(c.is_server));
        apb_write(REG_MTU_BYTES,    DATA_W'(c.mtu_bytes));
        apb_write(REG_CIPHER_ADDED, DATA_W'(c.cipher_added_bytes));
        cfg = c;
    endtask

    task automatic drive_row(input t_plan_row row);
        known_answers = {known_answers, row};
        in_item  <= row.item;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        n_items++;
        if (!quiet && !hold_req && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // receiver: random stall bursts, one long hold on request
    initial begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat (quiet ? 1 : $urandom_range(1, 30)) @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin
        t_plan_row row;
        t_out_item guess;
        t_out_item want;
        if (rst_n && in_valid && !in_stall) begin
            row   = known_answers.pop_front();
            guess = nonce_window_step(in_item);
            if (row.fixed) begin
                guess = row.answer;
            end
            pending_results = {pending_results, guess};
        end
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", out_item.issued_nonce, 64'd0);
            end else begin
                want = pending_results.pop_front();
                status_count[int'(want.status)]++;
                if (want.newest) begin
                    n_newest++;
                end
                if (out_item.status !== want.status) begin
                    report_mismatch("status", 64'(out_item.status), 64'(want.status));
                end
                if (out_item.issued_nonce !== want.issued_nonce) begin
                    report_mismatch("issued_nonce", out_item.issued_nonce, want.issued_nonce);
                end
                if (out_item.newest !== want.newest) begin
                    report_mismatch("newest", 64'(out_item.newest), 64'(want.newest));
                end
            end
        end
    end

    initial begin
        t_plan_row row;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        in_item   = '0;
        rst_n     = 1'b0;
        cfg       = '{1'b0, 16'd1400, 8'd16};
        send_ctr  = 64'd1;
        hi_seq    = '0;
        seen_map  = '0;
        err_count = 0;
        n_items   = 0;
        n_newest  = 0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        foreach (status_count[i]) begin
            status_count[i] = 0;
        end
        phase_cfg[0] = '{1'b1, 16'hFFFF, 8'd0};
        phase_cfg[1] = '{1'b0, 16'd0,    8'd255};
        phase_cfg[2] = '{1'b1, 16'd1500, 8'd255};
        phase_cfg[3] = '{1'b0, 16'hFFFF, 8'd255};
        phase_cfg[4] = '{1'b1, 16'd576,  8'd16};
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        build_plan();
        foreach (plan[i]) begin
            drive_row(plan[i]);
        end

        row.fixed  = 1'b0;
        row.answer = '0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_cfg(phase_cfg[p]);
            if (p == 2) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == NUM_PHASES - 1 && n == PHASE_ITEMS / 2) begin
                    quiet = 1'b1;
                end
                row.item = random_item();
                drive_row(row);
            end
        end

        settle();
        repeat (10) @(negedge clk);
        while (pending_results.size() != 0) begin
            report_mismatch("missing result", 64'd0, pending_results.pop_front().issued_nonce);
        end

        $display("Ran %0d items across %0d register settings: %0d ok, %0d too large,",
                 n_items, NUM_PHASES + 1, status_count[ST_OK], status_count[ST_TOO_LARGE]);
        $display("%0d bad direction or zero sequence, %0d replays, %0d window advances",
                 status_count[ST_BAD_DIR], status_count[ST_REPLAY], n_newest);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
src/nirw_pkg.sv
src/nirw_cfg.sv
src/nirw_proc.sv
src/nonce_issue_and_replay_window.sv
test/tb_nonce_issue_and_replay_window.sv
